// ===== rtl/ccm_pkg.sv =====
// ----------------------------------------------------------------------------
// ccm_pkg: shared definitions for the covariance / correlation matrix core
// Widths, status codes, register indexes, sequencer states and the control
// structs that pass between the sequencer and the shared divider.
// ----------------------------------------------------------------------------
package ccm_pkg;

    localparam int MAX_SERIES  = 8;
    localparam int MAX_SAMPLES = 256;

    localparam int SER_W  = $clog2(MAX_SERIES);
    localparam int IDX_W  = $clog2(MAX_SAMPLES);
    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int SMP_W  = 24;
    localparam int SUM_W  = SMP_W + IDX_W;
    localparam int DIFF_W = SMP_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + IDX_W;
    localparam int VOL_W  = ACC_W / 2;
    localparam int FRAC_SHIFT = 40;
    localparam int NUM_W  = ACC_W + FRAC_SHIFT;
    localparam int STEP_W = $clog2(NUM_W + 1);
    localparam int OUT_W  = 48;
    localparam int STAT_W = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_SHORT    = 3'd1;
    localparam logic [STAT_W-1:0] STAT_MISMATCH = 3'd2;
    localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd3;
    localparam logic [STAT_W-1:0] STAT_ZEROVAR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES = 1'd1;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MSUM,
        ST_MDIV,
        ST_MWAIT,
        ST_CRDX,
        ST_CRDY,
        ST_CMUL,
        ST_CACC,
        ST_CDIV,
        ST_CWAIT,
        ST_SRD,
        ST_SLD,
        ST_SWAIT,
        ST_ERD,
        ST_ELD,
        ST_ECALC,
        ST_EWAIT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } div_ctl_t;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_sts_t;

endpackage

// ===== rtl/covariance_correlation_matrix_core.sv =====
// ----------------------------------------------------------------------------
// covariance_correlation_matrix_core: sample covariance / correlation matrix
// Stores tagged Q3.20 samples, then on the end-of-load sample computes means,
// covariances and optionally correlations with one shared divider, one
// square-root unit and two multipliers, and emits the matrix row by row.
//
//   channel   handshake              fields
//   -------   ---------------------  ------------------------------------------
//   sample    start && !busy         series_index, sample_value, end_of_load
//   config    cfg_wen                cfg_index, cfg_wdata
//   result    result_valid (1 cycle) row_index, col_index, entry_value, status,
//                                    last_entry
//
// A sample without end of load is accepted while busy stays low.
// A run computes the means, then the covariances, then the roots, then emits
// the entries in covariance or correlation mode, using the single store read
// port, the bit-serial divider and the square-root unit.
// Reset clears counts and sets covariance mode with all series in use;
// no clearing pass is needed.
// Results cannot be stalled: each is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module covariance_correlation_matrix_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [ccm_pkg::SER_W-1:0]           series_index,
    input  logic signed [ccm_pkg::SMP_W-1:0]    sample_value,
    input  logic                                end_of_load,
    input  logic                                cfg_wen,
    input  logic [ccm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ccm_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    output logic                                result_valid,
    output logic [ccm_pkg::SER_W-1:0]           row_index,
    output logic [ccm_pkg::SER_W-1:0]           col_index,
    output logic signed [ccm_pkg::OUT_W-1:0]    entry_value,
    output logic [ccm_pkg::STAT_W-1:0]          status,
    output logic                                last_entry
);

    localparam int SER_W = ccm_pkg::SER_W;
    localparam int IDX_W = ccm_pkg::IDX_W;
    localparam int CNT_W = ccm_pkg::CNT_W;
    localparam int SMP_W = ccm_pkg::SMP_W;
    localparam int SUM_W = ccm_pkg::SUM_W;
    localparam int DIFF_W = ccm_pkg::DIFF_W;
    localparam int PROD_W = ccm_pkg::PROD_W;
    localparam int ACC_W = ccm_pkg::ACC_W;
    localparam int VOL_W = ccm_pkg::VOL_W;
    localparam int NUM_W = ccm_pkg::NUM_W;
    localparam int OUT_W = ccm_pkg::OUT_W;
    localparam int NSER = ccm_pkg::MAX_SERIES;
    localparam logic [ACC_W-1:0] LIM_POS = (ACC_W'(1) << (OUT_W - 1)) - ACC_W'(1);
    localparam logic [ACC_W-1:0] LIM_NEG = ACC_W'(1) << (OUT_W - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX = $signed(LIM_POS);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -$signed(LIM_NEG);

    ccm_pkg::state_t state_reg, state_next;

    logic                       mode_reg, mode_next;
    logic [CNT_W-1:0]           nuse_reg, nuse_next;
    logic [CNT_W-1:0]           cnt_reg [NSER];
    logic [CNT_W-1:0]           cnt_next [NSER];
    logic                       ovfs_reg, ovfs_next;
    logic signed [SMP_W-1:0]    mean_reg [NSER];
    logic signed [SMP_W-1:0]    mean_next [NSER];
    logic [VOL_W-1:0]           vol_reg [NSER];
    logic [VOL_W-1:0]           vol_next [NSER];
    logic [SER_W-1:0]           i_reg, i_next;
    logic [SER_W-1:0]           j_reg, j_next;
    logic [CNT_W-1:0]           k_reg, k_next;
    logic                       rdv_reg, rdv_next;
    logic                       sgn_reg, sgn_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [DIFF_W-1:0]   dx_reg, dx_next;
    logic signed [PROD_W-1:0]   prod_reg, prod_next;
    logic signed [ACC_W-1:0]    cov_reg, cov_next;
    logic [ACC_W-1:0]           den_reg, den_next;

    logic                       ov_valid_reg, ov_valid_next;
    logic                       ov_last_reg, ov_last_next;
    logic [SER_W-1:0]           ov_row_reg, ov_row_next;
    logic [SER_W-1:0]           ov_col_reg, ov_col_next;
    logic [OUT_W-1:0]           ov_val_reg, ov_val_next;
    logic [ccm_pkg::STAT_W-1:0] ov_stat_reg, ov_stat_next;

    logic                       accept;
    logic [CNT_W-1:0]           n_eff;
    logic [SER_W-1:0]           n_last;
    logic                       too_short;
    logic                       mismatch;
    logic                       last_pair;
    logic                       emit_fire;

    logic                       st_we;
    logic [SER_W+IDX_W-1:0]     st_waddr;
    logic [SER_W+IDX_W-1:0]     st_raddr;
    logic [SMP_W-1:0]           st_rdata;
    logic                       cv_we;
    logic [2*SER_W-1:0]         cv_raddr;
    logic [ACC_W-1:0]           cv_rdata;
    logic [SER_W-1:0]           lo_idx;
    logic [SER_W-1:0]           hi_idx;

    ccm_pkg::div_ctl_t          div_ctl;
    ccm_pkg::div_sts_t          div_sts;
    logic [NUM_W-1:0]           div_dividend;
    logic [ACC_W-1:0]           div_divisor;
    logic [ACC_W-1:0]           div_quo;
    logic                       sq_start;
    logic                       sq_done;
    logic [VOL_W-1:0]           sq_root;

    logic [SUM_W-1:0]           sum_mag;
    logic [ACC_W-1:0]           acc_mag;
    logic [ACC_W-1:0]           cov_mag;
    logic signed [DIFF_W-1:0]   dy;
    logic [SMP_W-1:0]           mean_q;
    logic [ACC_W-1:0]           cov_q;
    logic [ACC_W-1:0]           corr_lim;
    logic [ACC_W-1:0]           corr_mag;
    logic [OUT_W-1:0]           corr_val;
    logic [OUT_W-1:0]           cov_sat;

    assign busy   = state_reg != ccm_pkg::ST_IDLE;
    assign accept = start && !busy;

    // Zero series counts as one; anything above the maximum as the maximum.
    assign n_eff = (nuse_reg == '0) ? CNT_W'(1)
                 : (nuse_reg > CNT_W'(NSER)) ? CNT_W'(NSER) : nuse_reg;
    assign n_last = SER_W'(n_eff - CNT_W'(1));

    always_comb
    begin
        too_short = 1'b0;
        mismatch  = 1'b0;
        for (int s = 0; s < NSER; s++)
        begin
            if (CNT_W'(s) < n_eff)
            begin
                too_short = too_short | (cnt_reg[s] < CNT_W'(2));
                mismatch  = mismatch | (cnt_reg[s] != cnt_reg[0]);
            end
        end
    end

    assign last_pair = (i_reg == n_last) && (j_reg == n_last);
    assign emit_fire = ((state_reg == ccm_pkg::ST_ECALC) && (!mode_reg || den_reg == '0))
                    || ((state_reg == ccm_pkg::ST_EWAIT) && div_sts.done);

    assign lo_idx   = (i_reg < j_reg) ? i_reg : j_reg;
    assign hi_idx   = (i_reg < j_reg) ? j_reg : i_reg;
    assign st_we    = accept && (cnt_reg[series_index] < CNT_W'(ccm_pkg::MAX_SAMPLES));
    assign st_waddr = {series_index, cnt_reg[series_index][IDX_W-1:0]};
    assign st_raddr = {(state_reg == ccm_pkg::ST_CRDY) ? j_reg : i_reg, k_reg[IDX_W-1:0]};
    assign cv_raddr = (state_reg == ccm_pkg::ST_ERD) ? {lo_idx, hi_idx} : {i_reg, i_reg};
    assign cv_we    = (state_reg == ccm_pkg::ST_CWAIT) && div_sts.done;

    assign sum_mag = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign cov_mag = cov_reg[ACC_W-1] ? ACC_W'(-cov_reg) : ACC_W'(cov_reg);
    assign dy = $signed({st_rdata[SMP_W-1], st_rdata})
              - $signed({mean_reg[j_reg][SMP_W-1], mean_reg[j_reg]});
    assign mean_q = sgn_reg ? SMP_W'(-div_quo[SMP_W-1:0]) : div_quo[SMP_W-1:0];
    assign cov_q  = sgn_reg ? ACC_W'(-div_quo) : div_quo;

    // The quotient is clamped to the Q7.40 limit of its sign.
    assign corr_lim = sgn_reg ? LIM_NEG : LIM_POS;
    assign corr_mag = (div_sts.ovf || div_quo > corr_lim) ? corr_lim : div_quo;
    assign corr_val = sgn_reg ? OUT_W'(-corr_mag[OUT_W-1:0]) : corr_mag[OUT_W-1:0];
    assign cov_sat  = (cov_reg > SAT_MAX) ? SAT_MAX[OUT_W-1:0]
                    : (cov_reg < SAT_MIN) ? SAT_MIN[OUT_W-1:0] : cov_reg[OUT_W-1:0];

    always_comb
    begin
        div_ctl.start = 1'b0;
        div_ctl.steps = ccm_pkg::STEP_W'(ACC_W);
        div_dividend  = {acc_mag, {(NUM_W-ACC_W){1'b0}}};
        div_divisor   = ACC_W'(cnt_reg[0] - CNT_W'(1));
        case (state_reg)
            ccm_pkg::ST_MDIV:
            begin
                div_ctl.start = 1'b1;
                div_ctl.steps = ccm_pkg::STEP_W'(SUM_W);
                div_dividend  = {sum_mag, {(NUM_W-SUM_W){1'b0}}};
                div_divisor   = ACC_W'(cnt_reg[0]);
            end
            ccm_pkg::ST_CDIV:
            begin
                div_ctl.start = 1'b1;
            end
            ccm_pkg::ST_ECALC:
            begin
                div_ctl.start = mode_reg && (den_reg != '0);
                div_ctl.steps = ccm_pkg::STEP_W'(NUM_W);
                div_dividend  = {cov_mag, {(NUM_W-ACC_W){1'b0}}};
                div_divisor   = den_reg;
            end
            default:
            begin
                div_ctl.start = 1'b0;
            end
        endcase
    end

    assign sq_start = state_reg == ccm_pkg::ST_SLD;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ccm_pkg::ST_IDLE:
                if (accept && end_of_load)
                    state_next = ccm_pkg::ST_CHECK;
            ccm_pkg::ST_CHECK:
                if (ovfs_reg || too_short || mismatch)
                    state_next = ccm_pkg::ST_IDLE;
                else
                    state_next = ccm_pkg::ST_MSUM;
            ccm_pkg::ST_MSUM:
                if (k_reg >= cnt_reg[0] && !rdv_reg)
                    state_next = ccm_pkg::ST_MDIV;
            ccm_pkg::ST_MDIV:
                state_next = ccm_pkg::ST_MWAIT;
            ccm_pkg::ST_MWAIT:
                if (div_sts.done)
                    state_next = (i_reg == n_last) ? ccm_pkg::ST_CRDX : ccm_pkg::ST_MSUM;
            ccm_pkg::ST_CRDX:
                state_next = ccm_pkg::ST_CRDY;
            ccm_pkg::ST_CRDY:
                state_next = ccm_pkg::ST_CMUL;
            ccm_pkg::ST_CMUL:
                state_next = ccm_pkg::ST_CACC;
            ccm_pkg::ST_CACC:
                if (k_reg + CNT_W'(1) == cnt_reg[0])
                    state_next = ccm_pkg::ST_CDIV;
                else
                    state_next = ccm_pkg::ST_CRDX;
            ccm_pkg::ST_CDIV:
                state_next = ccm_pkg::ST_CWAIT;
            ccm_pkg::ST_CWAIT:
                if (div_sts.done)
                    state_next = last_pair ? ccm_pkg::ST_SRD : ccm_pkg::ST_CRDX;
            ccm_pkg::ST_SRD:
                state_next = ccm_pkg::ST_SLD;
            ccm_pkg::ST_SLD:
                state_next = ccm_pkg::ST_SWAIT;
            ccm_pkg::ST_SWAIT:
                if (sq_done)
                    state_next = (i_reg == n_last) ? ccm_pkg::ST_ERD : ccm_pkg::ST_SRD;
            ccm_pkg::ST_ERD:
                state_next = ccm_pkg::ST_ELD;
            ccm_pkg::ST_ELD:
                state_next = ccm_pkg::ST_ECALC;
            ccm_pkg::ST_ECALC:
                if (emit_fire)
                    state_next = last_pair ? ccm_pkg::ST_IDLE : ccm_pkg::ST_ERD;
                else
                    state_next = ccm_pkg::ST_EWAIT;
            ccm_pkg::ST_EWAIT:
                if (emit_fire)
                    state_next = last_pair ? ccm_pkg::ST_IDLE : ccm_pkg::ST_ERD;
            default:
                state_next = ccm_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        mode_next     = mode_reg;
        nuse_next     = nuse_reg;
        cnt_next      = cnt_reg;
        ovfs_next     = ovfs_reg;
        mean_next     = mean_reg;
        vol_next      = vol_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        rdv_next      = 1'b0;
        sgn_next      = sgn_reg;
        sum_next      = sum_reg;
        acc_next      = acc_reg;
        dx_next       = dx_reg;
        prod_next     = prod_reg;
        cov_next      = cov_reg;
        den_next      = den_reg;
        ov_valid_next = 1'b0;
        ov_last_next  = 1'b0;
        ov_row_next   = i_reg;
        ov_col_next   = j_reg;
        ov_val_next   = '0;
        ov_stat_next  = ccm_pkg::STAT_OK;

        if (cfg_wen)
        begin
            case (cfg_index)
                ccm_pkg::CFG_MODE:   mode_next = cfg_wdata[0];
                ccm_pkg::CFG_SERIES: nuse_next = CNT_W'(cfg_wdata);
                default:             mode_next = mode_reg;
            endcase
        end

        case (state_reg)
            ccm_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (st_we)
                        cnt_next[series_index] = cnt_reg[series_index] + CNT_W'(1);
                    else
                        ovfs_next = 1'b1;
                end
            end
            ccm_pkg::ST_CHECK:
            begin
                i_next   = '0;
                j_next   = '0;
                k_next   = '0;
                sum_next = '0;
                if (ovfs_reg || too_short || mismatch)
                begin
                    ov_valid_next = 1'b1;
                    ov_last_next  = 1'b1;
                    ov_row_next   = '0;
                    ov_col_next   = '0;
                    ov_stat_next  = ovfs_reg ? ccm_pkg::STAT_OVERFLOW
                                  : too_short ? ccm_pkg::STAT_SHORT : ccm_pkg::STAT_MISMATCH;
                    for (int s = 0; s < NSER; s++)
                        cnt_next[s] = '0;
                    ovfs_next = 1'b0;
                end
            end
            ccm_pkg::ST_MSUM:
            begin
                // Reads run one ahead of the adds because read data is registered.
                if (k_reg < cnt_reg[0])
                begin
                    k_next   = k_reg + CNT_W'(1);
                    rdv_next = 1'b1;
                end
                if (rdv_reg)
                    sum_next = sum_reg + SUM_W'($signed(st_rdata));
            end
            ccm_pkg::ST_MDIV:
            begin
                sgn_next = sum_reg[SUM_W-1];
            end
            ccm_pkg::ST_MWAIT:
            begin
                if (div_sts.done)
                begin
                    mean_next[i_reg] = mean_q;
                    k_next   = '0;
                    sum_next = '0;
                    acc_next = '0;
                    if (i_reg == n_last)
                    begin
                        i_next = '0;
                        j_next = '0;
                    end
                    else
                    begin
                        i_next = i_reg + SER_W'(1);
                    end
                end
            end
            ccm_pkg::ST_CRDY:
            begin
                dx_next = $signed({st_rdata[SMP_W-1], st_rdata})
                        - $signed({mean_reg[i_reg][SMP_W-1], mean_reg[i_reg]});
            end
            ccm_pkg::ST_CMUL:
            begin
                prod_next = dx_reg * dy;
            end
            ccm_pkg::ST_CACC:
            begin
                acc_next = acc_reg + ACC_W'(prod_reg);
                k_next   = k_reg + CNT_W'(1);
            end
            ccm_pkg::ST_CDIV:
            begin
                sgn_next = acc_reg[ACC_W-1];
            end
            ccm_pkg::ST_CWAIT:
            begin
                if (div_sts.done)
                begin
                    k_next   = '0;
                    acc_next = '0;
                    if (j_reg == n_last)
                    begin
                        if (i_reg == n_last)
                        begin
                            i_next = '0;
                        end
                        else
                        begin
                            i_next = i_reg + SER_W'(1);
                            j_next = i_reg + SER_W'(1);
                        end
                    end
                    else
                    begin
                        j_next = j_reg + SER_W'(1);
                    end
                end
            end
            ccm_pkg::ST_SWAIT:
            begin
                if (sq_done)
                begin
                    vol_next[i_reg] = sq_root;
                    if (i_reg == n_last)
                    begin
                        i_next = '0;
                        j_next = '0;
                    end
                    else
                    begin
                        i_next = i_reg + SER_W'(1);
                    end
                end
            end
            ccm_pkg::ST_ELD:
            begin
                cov_next = $signed(cv_rdata);
                den_next = vol_reg[i_reg] * vol_reg[j_reg];
            end
            ccm_pkg::ST_ECALC:
            begin
                sgn_next = cov_reg[ACC_W-1];
                if (!mode_reg)
                begin
                    ov_val_next = cov_sat;
                end
                else
                begin
                    ov_val_next  = '0;
                    ov_stat_next = ccm_pkg::STAT_ZEROVAR;
                end
            end
            ccm_pkg::ST_EWAIT:
            begin
                ov_val_next = corr_val;
            end
            default:
            begin
                rdv_next = 1'b0;
            end
        endcase

        if (emit_fire)
        begin
            ov_valid_next = 1'b1;
            ov_last_next  = last_pair;
            if (last_pair)
            begin
                for (int s = 0; s < NSER; s++)
                    cnt_next[s] = '0;
                ovfs_next = 1'b0;
            end
            else if (j_reg == n_last)
            begin
                i_next = i_reg + SER_W'(1);
                j_next = '0;
            end
            else
            begin
                j_next = j_reg + SER_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ccm_pkg::ST_IDLE;
            mode_reg     <= 1'b0;
            nuse_reg     <= CNT_W'(NSER);
            ovfs_reg     <= 1'b0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            rdv_reg      <= 1'b0;
            ov_valid_reg <= 1'b0;
            ov_last_reg  <= 1'b0;
            for (int s = 0; s < NSER; s++)
                cnt_reg[s] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            nuse_reg     <= nuse_next;
            ovfs_reg     <= ovfs_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            rdv_reg      <= rdv_next;
            ov_valid_reg <= ov_valid_next;
            ov_last_reg  <= ov_last_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mean_reg    <= mean_next;
        vol_reg     <= vol_next;
        sgn_reg     <= sgn_next;
        sum_reg     <= sum_next;
        acc_reg     <= acc_next;
        dx_reg      <= dx_next;
        prod_reg    <= prod_next;
        cov_reg     <= cov_next;
        den_reg     <= den_next;
        ov_row_reg  <= ov_row_next;
        ov_col_reg  <= ov_col_next;
        ov_val_reg  <= ov_val_next;
        ov_stat_reg <= ov_stat_next;
    end

    ccm_ram #(
        .WIDTH (SMP_W),
        .DEPTH (2 ** (SER_W + IDX_W))
    ) u_store (
        .clk   (clk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (sample_value),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    // Only the upper triangle is written; lower entries read their mirror.
    ccm_ram #(
        .WIDTH (ACC_W),
        .DEPTH (2 ** (2 * SER_W))
    ) u_cov (
        .clk   (clk),
        .we    (cv_we),
        .waddr ({i_reg, j_reg}),
        .wdata (cov_q),
        .raddr (cv_raddr),
        .rdata (cv_rdata)
    );

    ccm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .sts      (div_sts),
        .quotient (div_quo)
    );

    ccm_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (cv_rdata[ACC_W-1] ? '0 : cv_rdata),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign result_valid = ov_valid_reg;
    assign last_entry   = ov_last_reg;
    assign row_index    = ov_row_reg;
    assign col_index    = ov_col_reg;
    assign entry_value  = $signed(ov_val_reg);
    assign status       = ov_stat_reg;

    a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !last_entry) |-> busy)
        else $error("non-final result transfer outside a run");

    a_last_has_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_entry |-> result_valid)
        else $error("last_entry without a result transfer");

    a_eol_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && end_of_load) |=> busy)
        else $error("end of load did not start a run");

    a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == ccm_pkg::STAT_SHORT || status == ccm_pkg::STAT_MISMATCH
            || status == ccm_pkg::STAT_OVERFLOW))
        |-> (last_entry && row_index == '0 && col_index == '0))
        else $error("run error result is not a single final entry");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctl.start |=> !div_sts.done)
        else $error("divider finished right after a start");

endmodule

// ===== rtl/ccm_ram.sv =====
// ----------------------------------------------------------------------------
// ccm_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ccm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/ccm_div.sv =====
// ----------------------------------------------------------------------------
// ccm_div: shared unsigned restoring divider
// Takes one dividend bit per cycle from the top of a left-aligned dividend,
// for a given number of steps. Flags when a quotient bit is lost off the top.
// ----------------------------------------------------------------------------
module ccm_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ccm_pkg::div_ctl_t          ctl,
    input  logic [ccm_pkg::NUM_W-1:0]  dividend,
    input  logic [ccm_pkg::ACC_W-1:0]  divisor,
    output ccm_pkg::div_sts_t          sts,
    output logic [ccm_pkg::ACC_W-1:0]  quotient
);

    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;
    logic [ccm_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [ccm_pkg::NUM_W-1:0]    num_reg, num_next;
    logic [ccm_pkg::ACC_W-1:0]    den_reg, den_next;
    logic [ccm_pkg::ACC_W-1:0]    rem_reg, rem_next;
    logic [ccm_pkg::ACC_W-1:0]    quo_reg, quo_next;
    logic                         ovf_reg, ovf_next;
    logic [ccm_pkg::ACC_W:0]      trial;
    logic [ccm_pkg::ACC_W:0]      diff;
    logic                         fits;

    assign trial = {rem_reg, num_reg[ccm_pkg::NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (ctl.start)
        begin
            busy_next = 1'b1;
            step_next = ctl.steps;
            num_next  = dividend;
            den_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end
        else if (busy_reg)
        begin
            num_next  = {num_reg[ccm_pkg::NUM_W-2:0], 1'b0};
            rem_next  = fits ? diff[ccm_pkg::ACC_W-1:0] : trial[ccm_pkg::ACC_W-1:0];
            quo_next  = {quo_reg[ccm_pkg::ACC_W-2:0], fits};
            ovf_next  = ovf_reg | quo_reg[ccm_pkg::ACC_W-1];
            step_next = step_reg - ccm_pkg::STEP_W'(1);
            if (step_reg == ccm_pkg::STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign sts.done = done_reg;
    assign sts.ovf  = ovf_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/ccm_sqrt.sv =====
// ----------------------------------------------------------------------------
// ccm_sqrt: iterative integer square root
// Two radicand bits per cycle, floor of the root.
// ----------------------------------------------------------------------------
module ccm_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [ccm_pkg::ACC_W-1:0]  radicand,
    output logic                       done,
    output logic [ccm_pkg::VOL_W-1:0]  root
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [ccm_pkg::ACC_W-1:0]   v_reg, v_next;
    logic [ccm_pkg::ACC_W-1:0]   res_reg, res_next;
    logic [ccm_pkg::ACC_W-1:0]   bit_reg, bit_next;
    logic [ccm_pkg::ACC_W:0]     trial;

    assign trial = {1'b0, res_reg} + {1'b0, bit_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        if (start)
        begin
            busy_next = 1'b1;
            v_next    = radicand;
            res_next  = '0;
            bit_next  = ccm_pkg::ACC_W'(1) << (ccm_pkg::ACC_W - 2);
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next   = v_reg - trial[ccm_pkg::ACC_W-1:0];
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = res_reg[ccm_pkg::VOL_W-1:0];

endmodule
